>>> rtl/core/mid_pkg.sv
package mid_pkg;

   localparam logic OP_IMAGE = 1'b0;
   localparam logic OP_LOAD  = 1'b1;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_CUBIC = 2'd1;
   localparam logic [1:0] KIND_ORTHO = 2'd2;
   localparam logic [1:0] KIND_PARA  = 2'd3;

   localparam logic [1:0] REG_CELL_KIND = 2'd0;
   localparam logic [1:0] REG_LENGTH_X  = 2'd1;
   localparam logic [1:0] REG_LENGTH_Y  = 2'd2;
   localparam logic [1:0] REG_LENGTH_Z  = 2'd3;

   localparam int COEF_DEPTH = 18;
   localparam logic [4:0] FWD_BASE = 5'd9;
   localparam logic [4:0] COEF_END = 5'd18;

   typedef struct packed {
      logic             load;
      logic [4:0]       idx;
      logic [31:0]      val;
      logic [2:0][31:0] r1;
      logic [2:0][31:0] r2;
   } pipe_type;

endpackage

>>> rtl/core/minimum_image_displacement_core.sv
// Throughput: one item per cycle; the nine-register pipeline advances together
// and holds while a result waits on rsp_ready.
// Load items pass the pipeline and write their coefficient where that matrix is read.
// Reset clears the pipeline valid bits, the cell kind and length registers and both matrices to zero.
module minimum_image_displacement_core
   import mid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [4:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_first_z,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   input  logic signed [31:0] req_second_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_image_x,
   output logic signed [31:0] rsp_image_y,
   output logic signed [31:0] rsp_image_z,
   output logic signed [31:0] rsp_delta_x,
   output logic signed [31:0] rsp_delta_y,
   output logic signed [31:0] rsp_delta_z,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata
);

   localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
   localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;
   localparam logic signed [51:0] HALF    = 52'sd8388608;
   localparam logic signed [51:0] ONE     = 52'sd16777216;

   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      if (v > SAT_MAX) begin
         sat32 = SAT_MAX[31:0];
      end else if (v < SAT_MIN) begin
         sat32 = SAT_MIN[31:0];
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic logic signed [33:0] wrap_len(input logic signed [32:0] d,
                                                   input logic [30:0] len);
      logic signed [34:0] d2;
      logic signed [34:0] l;
      d2 = 35'(d) <<< 1;
      l  = $signed({4'b0, len});
      if (d2 < -l) begin
         wrap_len = 34'(35'(d) + l);
      end else if (d2 > l) begin
         wrap_len = 34'(35'(d) - l);
      end else begin
         wrap_len = 34'(d);
      end
   endfunction

   logic [1:0]  cell_kind_ff;
   logic [30:0] length_ff [3];
   logic signed [31:0] coef_ff [COEF_DEPTH];

   pipe_type pipe_ff [8];
   logic [7:0] vld_ff;

   logic signed [32:0] d_ff [3];
   logic signed [64:0] prod_ff [3][3];
   logic signed [51:0] acc_ff [3];
   logic signed [31:0] frac_ff [3];
   logic signed [63:0] fprod_ff [3][3];
   logic signed [35:0] dsum_ff [3];
   logic signed [33:0] dw_ff [2:6][3];
   logic signed [31:0] img_ff [3];

   logic               rsp_valid_ff;
   logic signed [31:0] image_ff [3];
   logic signed [31:0] delta_ff [3];

   logic en;
   pipe_type pipe_in;

   logic signed [32:0] d_in [3];
   logic signed [64:0] prod_in [3][3];
   logic signed [33:0] dw_in [3];
   logic signed [51:0] acc_in [3];
   logic signed [31:0] frac_in [3];
   logic signed [63:0] fprod_in [3][3];
   logic signed [35:0] dsum_in [3];
   logic signed [31:0] img_in [3];
   logic signed [31:0] delta_in [3];

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      pipe_in.load = (req_op == OP_LOAD);
      pipe_in.idx  = req_coef_index;
      pipe_in.val  = req_coef_value;
      pipe_in.r1   = {req_first_z, req_first_y, req_first_x};
      pipe_in.r2   = {req_second_z, req_second_y, req_second_x};
   end

   always_comb begin
      logic signed [51:0] sum;
      logic signed [31:0] s;
      logic signed [35:0] sum2;
      logic signed [35:0] dsel;
      for (int i = 0; i < 3; i++) begin
         d_in[i] = 33'($signed(pipe_ff[0].r1[i])) - 33'($signed(pipe_ff[0].r2[i]));
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = 65'(coef_ff[i*3+j]) * 65'(d_ff[j]);
            fprod_in[i][j] = 64'(coef_ff[9+i*3+j]) * 64'(frac_ff[j]);
         end
         if (cell_kind_ff == KIND_CUBIC) begin
            dw_in[i] = wrap_len(d_ff[i], length_ff[0]);
         end else begin
            dw_in[i] = wrap_len(d_ff[i], length_ff[i]);
         end
         sum = '0;
         for (int j = 0; j < 3; j++) begin
            sum = sum + 52'((66'(prod_ff[i][j]) + 66'sd32768) >>> 16);
         end
         acc_in[i] = sum;
         s = sat32(acc_ff[i]);
         if (52'(s) < -HALF) begin
            frac_in[i] = 32'(52'(s) + ONE);
         end else if (52'(s) > HALF) begin
            frac_in[i] = 32'(52'(s) - ONE);
         end else begin
            frac_in[i] = s;
         end
         sum2 = '0;
         for (int j = 0; j < 3; j++) begin
            sum2 = sum2 + 36'((65'(fprod_ff[i][j]) + 65'sd2147483648) >>> 32);
         end
         dsum_in[i] = sum2;
         if (cell_kind_ff == KIND_PARA) begin
            dsel = dsum_ff[i];
         end else begin
            dsel = 36'(dw_ff[6][i]);
         end
         if (cell_kind_ff == KIND_NONE) begin
            img_in[i] = $signed(pipe_ff[6].r1[i]);
         end else begin
            img_in[i] = sat32(52'($signed(pipe_ff[6].r2[i])) + 52'(dsel));
         end
         delta_in[i] = sat32(52'(img_ff[i]) - 52'($signed(pipe_ff[7].r2[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_kind_ff <= KIND_NONE;
         for (int i = 0; i < 3; i++) begin
            length_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_CELL_KIND: cell_kind_ff <= csr_wdata[1:0];
            REG_LENGTH_X:  length_ff[0] <= csr_wdata;
            REG_LENGTH_Y:  length_ff[1] <= csr_wdata;
            REG_LENGTH_Z:  length_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The inverse matrix is written where it is read, the forward matrix likewise,
   // so every item sees exactly the loads that came before it.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < COEF_DEPTH; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (en) begin
         if (vld_ff[1] && pipe_ff[1].load && pipe_ff[1].idx < FWD_BASE) begin
            coef_ff[pipe_ff[1].idx] <= $signed(pipe_ff[1].val);
         end
         if (vld_ff[4] && pipe_ff[4].load && pipe_ff[4].idx >= FWD_BASE &&
             pipe_ff[4].idx < COEF_END) begin
            coef_ff[pipe_ff[4].idx] <= $signed(pipe_ff[4].val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[6:0], req_valid};
         rsp_valid_ff <= vld_ff[7] && !pipe_ff[7].load;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= pipe_in;
         for (int k = 1; k < 8; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            d_ff[i]     <= d_in[i];
            dw_ff[2][i] <= dw_in[i];
            for (int k = 3; k < 7; k++) begin
               dw_ff[k][i] <= dw_ff[k-1][i];
            end
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j]  <= prod_in[i][j];
               fprod_ff[i][j] <= fprod_in[i][j];
            end
            acc_ff[i]   <= acc_in[i];
            frac_ff[i]  <= frac_in[i];
            dsum_ff[i]  <= dsum_in[i];
            img_ff[i]   <= img_in[i];
            image_ff[i] <= img_ff[i];
            delta_ff[i] <= delta_in[i];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_image_x = image_ff[0];
   assign rsp_image_y = image_ff[1];
   assign rsp_image_z = image_ff[2];
   assign rsp_delta_x = delta_ff[0];
   assign rsp_delta_y = delta_ff[1];
   assign rsp_delta_z = delta_ff[2];

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import mid_pkg::*;
();

   typedef struct {
      logic       op;
      logic [4:0] idx;
      int         val;
      int         r1[3];
      int         r2[3];
   } pair_item_type;

   typedef struct {
      int img[3];
      int dlt[3];
   } image_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = OP_IMAGE;
   logic [4:0]         req_coef_index = '0;
   logic signed [31:0] req_coef_value = '0;
   logic signed [31:0] req_first_x = '0;
   logic signed [31:0] req_first_y = '0;
   logic signed [31:0] req_first_z = '0;
   logic signed [31:0] req_second_x = '0;
   logic signed [31:0] req_second_y = '0;
   logic signed [31:0] req_second_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_image_x, rsp_image_y, rsp_image_z;
   logic signed [31:0] rsp_delta_x, rsp_delta_y, rsp_delta_z;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = REG_CELL_KIND;
   logic [30:0]        csr_wdata = '0;

   pair_item_type    pending_items[$];
   image_result_type expected_images[$];
   pair_item_type    cur_item;
   int               send_gap = 0;
   int               recv_wait = 0;
   int               rsp_hold = 0;
   bit               idle_on = 1'b1;
   int               error_count = 0;

   logic [1:0] cell_kind_now = KIND_NONE;
   longint     cell_len[3] = '{0, 0, 0};
   int         coef_copy[COEF_DEPTH];

   minimum_image_displacement_core DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint wrap_once(longint d, longint len);
      if (2 * d < -len) return d + len;
      if (2 * d > len) return d - len;
      return d;
   endfunction

   function automatic void predict_image(pair_item_type it);
      longint           d[3], fr[3], acc;
      image_result_type res;
      if (it.op == OP_LOAD) begin
         if (it.idx < COEF_END) coef_copy[it.idx] = it.val;
         return;
      end
      for (int i = 0; i < 3; i++) d[i] = longint'(it.r1[i]) - longint'(it.r2[i]);
      case (cell_kind_now)
         KIND_CUBIC: for (int i = 0; i < 3; i++) d[i] = wrap_once(d[i], cell_len[0]);
         KIND_ORTHO: for (int i = 0; i < 3; i++) d[i] = wrap_once(d[i], cell_len[i]);
         KIND_PARA: begin
            for (int i = 0; i < 3; i++) begin
               acc = 0;
               for (int j = 0; j < 3; j++)
                  acc += round_shift(longint'(coef_copy[i*3+j]) * d[j], 16);
               acc = sat32(acc);
               if (acc < -(longint'(1) <<< 23)) acc += longint'(1) <<< 24;
               else if (acc > (longint'(1) <<< 23)) acc -= longint'(1) <<< 24;
               fr[i] = acc;
            end
            for (int i = 0; i < 3; i++) begin
               acc = 0;
               for (int j = 0; j < 3; j++)
                  acc += round_shift(longint'(coef_copy[FWD_BASE+i*3+j]) * fr[j], 32);
               d[i] = acc;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < 3; i++) begin
         if (cell_kind_now == KIND_NONE) res.img[i] = it.r1[i];
         else res.img[i] = int'(sat32(longint'(it.r2[i]) + d[i]));
         res.dlt[i] = int'(sat32(longint'(res.img[i]) - longint'(it.r2[i])));
      end
      expected_images.push_back(res);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_image(cur_item);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            cur_item = pending_items.pop_front();
            req_op <= cur_item.op;
            req_coef_index <= cur_item.idx;
            req_coef_value <= cur_item.val;
            req_first_x <= cur_item.r1[0];
            req_first_y <= cur_item.r1[1];
            req_first_z <= cur_item.r1[2];
            req_second_x <= cur_item.r2[0];
            req_second_y <= cur_item.r2[1];
            req_second_z <= cur_item.r2[2];
            req_valid <= 1'b1;
            send_gap = idle_on ? $urandom_range(0, 14) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      image_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_images.size() == 0) begin
               report_mismatch("surplus result item", rsp_image_x, 0);
            end else begin
               want = expected_images.pop_front();
               if (rsp_image_x !== want.img[0]) report_mismatch("image_x", rsp_image_x, want.img[0]);
               if (rsp_image_y !== want.img[1]) report_mismatch("image_y", rsp_image_y, want.img[1]);
               if (rsp_image_z !== want.img[2]) report_mismatch("image_z", rsp_image_z, want.img[2]);
               if (rsp_delta_x !== want.dlt[0]) report_mismatch("delta_x", rsp_delta_x, want.dlt[0]);
               if (rsp_delta_y !== want.dlt[1]) report_mismatch("delta_y", rsp_delta_y, want.dlt[1]);
               if (rsp_delta_z !== want.dlt[2]) report_mismatch("delta_z", rsp_delta_z, want.dlt[2]);
            end
            recv_wait = idle_on ? $urandom_range(0, 14) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [1:0] index, logic [30:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_CELL_KIND) cell_kind_now = value[1:0];
      else cell_len[index - 1] = longint'(value);
   endtask

   task automatic set_cell(logic [1:0] kind, logic [30:0] lx, logic [30:0] ly,
                           logic [30:0] lz);
      write_reg(REG_CELL_KIND, {29'd0, kind});
      write_reg(REG_LENGTH_X, lx);
      write_reg(REG_LENGTH_Y, ly);
      write_reg(REG_LENGTH_Z, lz);
   endtask

   task automatic add_pair(int r1x, int r1y, int r1z, int r2x, int r2y, int r2z);
      pair_item_type it;
      it.op = OP_IMAGE;
      it.idx = 5'($urandom_range(0, 31));
      it.val = $urandom;
      it.r1 = '{r1x, r1y, r1z};
      it.r2 = '{r2x, r2y, r2z};
      pending_items.push_back(it);
   endtask

   task automatic add_load(int index, int value);
      pair_item_type it;
      it.op = OP_LOAD;
      it.idx = 5'(index);
      it.val = value;
      for (int i = 0; i < 3; i++) begin
         it.r1[i] = $urandom;
         it.r2[i] = $urandom;
      end
      pending_items.push_back(it);
   endtask

   function automatic int near_value(int centre, int span);
      return int'(sat32(longint'(centre) + longint'($urandom_range(0, 2 * span)) - span));
   endfunction

   task automatic add_random_pairs(int count, int span);
      int c[3];
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_load($urandom_range(0, 31), $urandom);
         end else if ($urandom_range(0, 4) == 0) begin
            add_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            for (int i = 0; i < 3; i++) c[i] = near_value(0, 2 * span);
            add_pair(near_value(c[0], 3 * span / 2), near_value(c[1], 3 * span / 2),
                     near_value(c[2], 3 * span / 2), c[0], c[1], c[2]);
         end
      end
   endtask

   task automatic load_random_cell(output int span);
      real a, b, c, p, q, r;
      real m[9];
      a = $urandom_range(2000, 30000) / 1000.0;
      b = $urandom_range(2000, 30000) / 1000.0;
      c = $urandom_range(2000, 30000) / 1000.0;
      p = ($urandom_range(0, 2000) / 1000.0 - 1.0) * a / 2.0;
      q = ($urandom_range(0, 2000) / 1000.0 - 1.0) * a / 2.0;
      r = ($urandom_range(0, 2000) / 1000.0 - 1.0) * b / 2.0;
      m = '{1.0 / a, -p / (a * b), (p * r - q * b) / (a * b * c),
            0.0, 1.0 / b, -r / (b * c), 0.0, 0.0, 1.0 / c};
      for (int i = 0; i < 9; i++) add_load(i, $rtoi(m[i] * 16777216.0));
      m = '{a, p, q, 0.0, b, r, 0.0, 0.0, c};
      for (int i = 0; i < 9; i++) add_load(FWD_BASE + i, $rtoi(m[i] * 16777216.0));
      span = $rtoi((a + b + c) * 65536.0 / 2.0);
   endtask

   task automatic drain;
      while (pending_items.size() > 0 || req_valid || expected_images.size() > 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   initial begin
      int span;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      set_cell(KIND_NONE, 31'd0, 31'd0, 31'd0);
      add_pair(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 0);
      add_pair(32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 32'h80000000, -1);
      add_load(31, 32'h12345678);
      add_load(18, 32'h7fffffff);
      add_pair(0, 0, 0, 0, 0, 0);
      drain();

      set_cell(KIND_CUBIC, 31'd655360, 31'd0, 31'd0);
      add_pair(327680, -327680, 327681, 0, 0, 0);
      add_pair(-327681, 327679, -327680, 0, 0, 0);
      add_pair(32'h7fff0000 - 393216, 32'h80000000 + 393216, 0,
               32'h7fff0000, 32'h80000000, 600000);
      add_random_pairs(120, 655360);
      drain();

      set_cell(KIND_CUBIC, 31'd0, 31'h7fffffff, 31'd5);
      add_random_pairs(40, 65536);
      drain();

      set_cell(KIND_CUBIC, 31'h7fffffff, 31'd0, 31'd0);
      add_pair(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0, 32'h7fffffff);
      add_random_pairs(80, 32'h3fffffff);
      drain();

      set_cell(KIND_ORTHO, 31'd196608, 31'd491520, 31'd802816);
      @(negedge clock);
      rsp_hold = 400;
      add_random_pairs(150, 600000);
      drain();

      set_cell(KIND_PARA, 31'd0, 31'd0, 31'd0);
      load_random_cell(span);
      add_pair(span, -span, span / 3, 0, 0, 0);
      add_random_pairs(100, span);
      load_random_cell(span);
      add_random_pairs(100, span);
      drain();

      add_load(0, 32'h80000000);
      add_load(4, 32'h7fffffff);
      add_load(FWD_BASE, 32'h7fffffff);
      add_load(FWD_BASE + 8, 32'h80000000);
      add_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
      add_pair(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      for (int n = 0; n < 100; n++) begin
         if ($urandom_range(0, 3) == 0) add_load($urandom_range(0, 17), $urandom);
         else add_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      drain();

      idle_on = 1'b0;
      set_cell(KIND_NONE, 31'd1, 31'd1, 31'd1);
      add_random_pairs(60, 1000000);
      drain();
      idle_on = 1'b1;

      set_cell(KIND_ORTHO, 31'h7fffffff, 31'd0, 31'h7fffffff);
      add_random_pairs(50, 32'h3fffffff);
      drain();

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

endmodule
